### rtl/wra_pkg.sv
// Shared types, constants and command codes of the windowed resample averager.
`default_nettype none
package wra_pkg;

  localparam int unsigned NumComponents = 3;
  localparam int unsigned CountBits     = 16;
  localparam int unsigned AddrWidth     = 3;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_REF   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_HALF_WINDOW = 1'b0,
    REG_UNMAPPED    = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        item_time;
    logic signed [23:0] value_0;
    logic signed [23:0] value_1;
    logic signed [23:0] value_2;
    logic [2:0]         invalid_in;
  } in_t;

  typedef struct packed {
    logic [31:0]        ref_time;
    logic signed [23:0] mean_0;
    logic signed [23:0] mean_1;
    logic signed [23:0] mean_2;
    logic [2:0]         invalid_out;
    logic [15:0]        sample_count;
    logic               last;
  } out_t;

endpackage
`default_nettype wire

### rtl/wra_div_lane.sv
// One divider lane: rounded signed mean of a window sum, one quotient bit per cycle.
`default_nettype none
module wra_div_lane
  import wra_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [24+COUNT_BITS-1:0] sum_i,
  input  wire logic [COUNT_BITS-1:0]          count_i,
  output logic                                busy_o,
  output logic signed [23:0]                  mean_o
);

  localparam int unsigned SumW  = 24 + COUNT_BITS;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]       num_q, num_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d, den_q;
  logic [StepW-1:0]      step_q, step_d;
  logic                  busy_q, busy_d, neg_q;
  logic [SumW-1:0]       mag;
  logic [COUNT_BITS:0]   part, diff;
  logic                  ge;
  logic [23:0]           q24;

  always_comb begin
    mag  = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
    part = {rem_q, num_q[SumW-1]};
    diff = part - {1'b0, den_q};
    ge   = part >= {1'b0, den_q};
    rem_d  = rem_q;
    num_d  = num_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      // Adding half the divisor gives round to nearest, ties away from zero.
      num_d  = mag + SumW'(count_i >> 1);
      rem_d  = '0;
      step_d = StepW'(SumW);
      busy_d = (count_i != '0);
      if (count_i == '0) begin
        num_d = '0;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[COUNT_BITS-1:0] : part[COUNT_BITS-1:0];
      num_d  = {num_q[SumW-2:0], ge};
      step_d = step_q - StepW'(1);
      busy_d = (step_q != StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= count_i;
      neg_q <= sum_i[SumW-1];
    end
  end

  assign q24    = num_q[23:0];
  assign busy_o = busy_q;
  assign mean_o = neg_q ? -q24 : q24;

endmodule
`default_nettype wire

### rtl/windowed_resample_average.sv
// An item is registered in ST_IDLE and decided in ST_EXEC. A closed window goes on through
// ST_DIV, where the bit-serial divider lanes run (24 + COUNT_BITS quotient bits, one per
// cycle), and then ST_EMIT. An empty second window passes through ST_DIV and ST_EMIT again.
// The block takes no new item until it is through with the last one, and an output stall
// holds it in ST_EMIT. One item is worked at a time.
// Reset clears the window state, the held-sample flag, half_window and the output valid.
`default_nettype none
module windowed_resample_average
  import wra_pkg::*;
#(
  parameter int unsigned COMPONENTS = NumComponents,
  parameter int unsigned COUNT_BITS = CountBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned SumW = 24 + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [2:0] UnusedMask = 3'b111 & ~3'((1 << COMPONENTS) - 1);
  localparam logic [2:0] UsedMask   = ~UnusedMask;

  state_e state_q, state_d;

  logic [31:0] hw_q;
  in_t         it_q;

  logic                   open_q, open_d;
  logic [31:0]            ref_q, ref_d;
  logic signed [SumW-1:0] sum_q [COMPONENTS];
  logic signed [SumW-1:0] sum_d [COMPONENTS];
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [2:0]             mask_q, mask_d;
  logic                   held_q, held_d;
  logic [31:0]            htime_q;
  logic signed [23:0]     hval_q [3];
  logic [2:0]             hinv_q;
  logic                   pend2_q, pend2_d;

  logic [31:0]           m_ref_q;
  logic [2:0]            m_inv_q;
  logic [COUNT_BITS-1:0] m_cnt_q;
  logic                  m_last_q;

  out_t out_q;
  logic out_valid_q;

  logic signed [23:0] vin [3];
  logic [32:0] t_ext, ref_ext, ht_ext, hw_ext;
  logic        bef, aft, hbef, haft;
  logic        close1, close2, hold_item, out_free, start;
  logic        cfg_wr;
  logic        lane_busy [COMPONENTS];
  logic signed [23:0] lane_mean [COMPONENTS];
  logic signed [23:0] mean [3];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (reg_e'(paddr[2]) == REG_HALF_WINDOW);
  assign prdata = (reg_e'(paddr[2]) == REG_HALF_WINDOW) ? hw_q : 32'd0;

  assign vin[0] = it_q.value_0;
  assign vin[1] = it_q.value_1;
  assign vin[2] = it_q.value_2;

  // Window placement, computed one bit wider so nothing wraps.
  always_comb begin
    t_ext   = {1'b0, it_q.item_time};
    ref_ext = {1'b0, ref_q};
    ht_ext  = {1'b0, htime_q};
    hw_ext  = {1'b0, hw_q};
    bef  = (t_ext + hw_ext) < ref_ext;
    aft  = t_ext > (ref_ext + hw_ext);
    hbef = (ht_ext + hw_ext) < t_ext;
    haft = ht_ext > (t_ext + hw_ext);
  end

  // Per-item decision and window state update.
  always_comb begin
    open_d    = open_q;
    ref_d     = ref_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    held_d    = held_q;
    close1    = 1'b0;
    close2    = 1'b0;
    hold_item = 1'b0;
    if (state_q == ST_EXEC) begin
      case (cmd_e'(it_q.command))
        CMD_DATA: begin
          if (open_q) begin
            if (!bef && !aft) begin
              mask_d = mask_q | (it_q.invalid_in & UsedMask);
              if (cnt_q != CountMax) begin
                cnt_d = cnt_q + COUNT_BITS'(1);
                for (int c = 0; c < COMPONENTS; c++) begin
                  sum_d[c] = sum_q[c] + SumW'(vin[c]);
                end
              end
            end else if (aft) begin
              close1    = 1'b1;
              open_d    = 1'b0;
              hold_item = 1'b1;
            end
          end else begin
            hold_item = 1'b1;
          end
        end
        CMD_REF: begin
          close1 = open_q;
          open_d = 1'b1;
          ref_d  = it_q.item_time;
          cnt_d  = '0;
          mask_d = '0;
          for (int c = 0; c < COMPONENTS; c++) begin
            sum_d[c] = '0;
          end
          if (held_q) begin
            if (haft) begin
              // The held sample lies beyond the new window: it closes empty.
              close2 = 1'b1;
              open_d = 1'b0;
            end else begin
              held_d = 1'b0;
              if (!hbef) begin
                cnt_d  = COUNT_BITS'(1);
                mask_d = hinv_q & UsedMask;
                for (int c = 0; c < COMPONENTS; c++) begin
                  sum_d[c] = SumW'(hval_q[c]);
                end
              end
            end
          end
        end
        CMD_FLUSH: begin
          close1 = open_q;
          open_d = 1'b0;
        end
        default: begin
        end
      endcase
      if (hold_item) begin
        held_d = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = (close1 || close2) ? ST_DIV : ST_IDLE;
      ST_DIV:  if (!lane_busy[0]) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = pend2_q ? ST_DIV : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    start      = 1'b0;
    pend2_d    = pend2_q;
    case (state_q)
      ST_EXEC: begin
        start   = close1 || close2;
        pend2_d = close1 && close2;
      end
      ST_EMIT: begin
        start = out_free && pend2_q;
        if (out_free) pend2_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Divider lanes, one per component.
  for (genvar c = 0; c < COMPONENTS; c++) begin : g_lane
    logic signed [SumW-1:0] lsum;
    assign lsum = (state_q == ST_EXEC && close1) ? sum_q[c] : '0;
    wra_div_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(start),
      .sum_i  (lsum),
      .count_i((state_q == ST_EXEC && close1) ? cnt_q : '0),
      .busy_o (lane_busy[c]),
      .mean_o (lane_mean[c])
    );
  end

  // Merge the lanes into one result.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mean[c] = '0;
    end
    for (int c = 0; c < COMPONENTS; c++) begin
      if (!m_inv_q[c]) mean[c] = lane_mean[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hw_q        <= '0;
      open_q      <= 1'b0;
      ref_q       <= '0;
      cnt_q       <= '0;
      mask_q      <= '0;
      held_q      <= 1'b0;
      pend2_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < COMPONENTS; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) hw_q <= pwdata;
      open_q  <= open_d;
      ref_q   <= ref_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      mask_q  <= mask_d;
      held_q  <= held_d;
      pend2_q <= pend2_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) it_q <= in_data_i;
    if (hold_item) begin
      htime_q <= it_q.item_time;
      hinv_q  <= it_q.invalid_in;
      for (int c = 0; c < 3; c++) begin
        hval_q[c] <= vin[c];
      end
    end
    if (state_q == ST_EXEC && close1) begin
      m_ref_q  <= ref_q;
      m_cnt_q  <= cnt_q;
      m_inv_q  <= mask_q | ((cnt_q == '0) ? 3'b111 : 3'b000) | UnusedMask;
      m_last_q <= !close2;
    end else if (start) begin
      // Empty window closed by a held sample beyond the new reference.
      m_ref_q  <= it_q.item_time;
      m_cnt_q  <= '0;
      m_inv_q  <= 3'b111;
      m_last_q <= 1'b1;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q.ref_time    <= m_ref_q;
      out_q.mean_0      <= mean[0];
      out_q.mean_1      <= mean[1];
      out_q.mean_2      <= mean[2];
      out_q.invalid_out <= m_inv_q;
      out_q.sample_count <= (COUNT_BITS > 16 && 32'(m_cnt_q) > 32'd65535) ?
                            16'hFFFF : 16'(m_cnt_q);
      out_q.last        <= m_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
